// ===== hdl/ffa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the free-list allocator
// Field widths, register indexes, codes, sequencer states and the structs
// that travel between the allocator modules.
// ----------------------------------------------------------------------------
package ffa_pkg;

	// Field widths
	localparam int SIZE_W = 17;
	localparam int POS_W  = 16;
	localparam int IDX_W  = 2;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_HEAP_START    = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEAP_LIMIT    = 2'd1;
	localparam logic [IDX_W-1:0] REG_MIN_REMAINDER = 2'd2;

	// Register values after reset
	localparam logic [SIZE_W-1:0] HEAP_START_RST    = 17'd0;
	localparam logic [SIZE_W-1:0] HEAP_LIMIT_RST    = 17'd65536;
	localparam logic [SIZE_W-1:0] MIN_REMAINDER_RST = 17'd16;

	// Request and result codes
	localparam logic MODE_ALLOC     = 1'b0;
	localparam logic MODE_FREE      = 1'b1;
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_NOSPACE = 1'b1;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_WALK,
		ST_UNLINK_P,
		ST_UNLINK_N,
		ST_PUSH_REC,
		ST_PUSH_PREV,
		ST_BUMP,
		ST_DONE
	} state_t;

	// Configuration seen by the sequencer
	typedef struct packed {
		logic [SIZE_W-1:0] heap_limit;
		logic [SIZE_W-1:0] min_remainder;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic              status;
		logic [POS_W-1:0]  position;
		logic [SIZE_W-1:0] granted_size;
		logic [SIZE_W-1:0] free_total;
	} result_t;

	// Field write enables of a node record
	typedef struct packed {
		logic size;
		logic prev;
		logic next;
	} field_mask_t;

endpackage

// ===== hdl/ffa_node_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_node_mem: free-list node record memory
// Single-port synchronous memory of node records {size, prev, next}, one per
// granule, with a write enable per field and registered read data.
// ----------------------------------------------------------------------------
module ffa_node_mem
	import ffa_pkg::*;
#(
	parameter int DEPTH = 8192,
	parameter int AW    = 13,
	parameter int PW    = 14
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic              wr_en,
	input  field_mask_t       wr_mask,
	input  logic [AW-1:0]     addr,
	input  logic [SIZE_W-1:0] wr_size,
	input  logic [PW-1:0]     wr_prev,
	input  logic [PW-1:0]     wr_next,
	output logic [SIZE_W-1:0] rd_size,
	output logic [PW-1:0]     rd_prev,
	output logic [PW-1:0]     rd_next
);

	logic [SIZE_W-1:0] size_mem [DEPTH];
	logic [PW-1:0]     prev_mem [DEPTH];
	logic [PW-1:0]     next_mem [DEPTH];

	// Write the enabled fields of one record
	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (wr_mask.size) begin
				size_mem[addr] <= wr_size;
			end
			if (wr_mask.prev) begin
				prev_mem[addr] <= wr_prev;
			end
			if (wr_mask.next) begin
				next_mem[addr] <= wr_next;
			end
		end
	end

	// Read one record, hold the data between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_size <= size_mem[addr];
			rd_prev <= prev_mem[addr];
			rd_next <= next_mem[addr];
		end
	end

endmodule

// ===== hdl/ffa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_ctrl: allocator sequencer
// Walks the free list through the node memory, unlinks and pushes records,
// keeps the list head, the free byte total and the bump pointer.
// ----------------------------------------------------------------------------
module ffa_ctrl
	import ffa_pkg::*;
#(
	parameter int ARENA_BYTES = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              bump_load,
	input  logic [SIZE_W-1:0] bump_value,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_mode,
	input  logic [SIZE_W-1:0] in_size,
	input  logic [POS_W-1:0]  in_pos,
	input  logic              out_free,
	output logic              res_valid,
	output result_t           res
);

	localparam int NODE_COUNT = ARENA_BYTES / 8;
	localparam int AW         = $clog2(NODE_COUNT);
	localparam int PW         = AW + 1;
	localparam int STW        = $clog2(NODE_COUNT + 1);
	localparam int CW         = ($clog2(ARENA_BYTES) + 2 > 19) ? $clog2(ARENA_BYTES) + 2 : 19;
	localparam logic [CW-1:0]  ARENA_C = CW'(ARENA_BYTES);
	localparam logic [CW-1:0]  NODES_C = CW'(NODE_COUNT);
	localparam logic [STW-1:0] STEPS_C = STW'(NODE_COUNT);
	localparam logic [PW-1:0]  NONE    = '1;

	state_t            state_q, state_d;
	logic              mode_q;
	logic [SIZE_W-1:0] size_q;
	logic [POS_W-1:0]  pos_q;
	logic [SIZE_W:0]   rounded_q;
	logic [PW-1:0]     head_q;
	logic [SIZE_W-1:0] free_bytes_q;
	logic [SIZE_W-1:0] bump_q;
	logic [PW-1:0]     cur_q;
	logic [STW-1:0]    steps_q;
	logic [PW-1:0]     prev_q;
	logic [PW-1:0]     next_q;
	logic [SIZE_W-1:0] nsize_q;
	logic [SIZE_W-1:0] diff_q;
	logic [PW-1:0]     push_idx_q;
	logic [SIZE_W-1:0] push_size_q;
	logic              status_q;
	logic [POS_W-1:0]  grant_q;

	logic              mem_rd_en;
	logic              mem_wr_en;
	field_mask_t       mem_wr_mask;
	logic [AW-1:0]     mem_addr;
	logic [SIZE_W-1:0] mem_wr_size;
	logic [PW-1:0]     mem_wr_prev;
	logic [PW-1:0]     mem_wr_next;
	logic [SIZE_W-1:0] mem_rd_size;
	logic [PW-1:0]     mem_rd_prev;
	logic [PW-1:0]     mem_rd_next;

	logic [SIZE_W:0]   rounded_in;
	logic              too_big;
	logic [CW-1:0]     free_idx;
	logic              free_idx_ok;
	logic              head_ok;
	logic [SIZE_W:0]   diff_w;
	logic              fit;
	logic [STW-1:0]    steps_nx;
	logic              walk_more;
	logic [CW-1:0]     rem_idx;
	logic              rem_ok;
	logic [CW-1:0]     limit;
	logic [CW-1:0]     bump_sum;
	logic              bump_ok;
	logic [CW-1:0]     cur_byte;

	function automatic logic ptr_ok(input logic [PW-1:0] p);
		return CW'(p) < NODES_C;
	endfunction

	function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
	                                              input logic [SIZE_W-1:0] b);
		logic [SIZE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SIZE_W] ? '1 : s[SIZE_W-1:0];
	endfunction

	function automatic logic [SIZE_W-1:0] sat_sub(input logic [SIZE_W-1:0] a,
	                                              input logic [SIZE_W-1:0] b);
		return (b > a) ? '0 : a - b;
	endfunction

	ffa_node_mem #(
		.DEPTH (NODE_COUNT),
		.AW    (AW),
		.PW    (PW)
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.wr_en   (mem_wr_en),
		.wr_mask (mem_wr_mask),
		.addr    (mem_addr),
		.wr_size (mem_wr_size),
		.wr_prev (mem_wr_prev),
		.wr_next (mem_wr_next),
		.rd_size (mem_rd_size),
		.rd_prev (mem_rd_prev),
		.rd_next (mem_rd_next)
	);

	// Decode request, fit test, remainder and bump arithmetic
	always_comb begin
		rounded_in  = ({1'b0, in_size} + (SIZE_W+1)'(7)) & ~((SIZE_W+1)'(7));
		too_big     = CW'(rounded_q) > ARENA_C;
		free_idx    = CW'(pos_q[POS_W-1:3]);
		free_idx_ok = free_idx < NODES_C;
		head_ok     = ptr_ok(head_q);
		diff_w      = {1'b0, mem_rd_size} - rounded_q;
		fit         = ({1'b0, mem_rd_size} == rounded_q) ||
		              (({1'b0, mem_rd_size} > rounded_q) &&
		               (diff_w >= {1'b0, cfg.min_remainder}));
		steps_nx    = steps_q + STW'(1);
		walk_more   = ptr_ok(mem_rd_next) && (steps_nx < STEPS_C);
		rem_idx     = CW'(cur_q) + CW'(rounded_q[SIZE_W:3]);
		rem_ok      = rem_idx < NODES_C;
		limit       = (CW'(cfg.heap_limit) < ARENA_C) ? CW'(cfg.heap_limit) : ARENA_C;
		bump_sum    = CW'(bump_q) + CW'(rounded_q);
		bump_ok     = (CW'(bump_q) < ARENA_C) && (bump_sum <= limit);
		cur_byte    = CW'(cur_q) << 3;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (mode_q == MODE_FREE) begin
					state_d = free_idx_ok ? ST_PUSH_REC : ST_DONE;
				end else if (too_big) begin
					state_d = ST_DONE;
				end else if (head_ok) begin
					state_d = ST_WALK;
				end else begin
					state_d = ST_BUMP;
				end
			end
			ST_WALK: begin
				if (fit) begin
					state_d = ST_UNLINK_P;
				end else if (walk_more) begin
					state_d = ST_WALK;
				end else begin
					state_d = ST_BUMP;
				end
			end
			ST_UNLINK_P: state_d = ST_UNLINK_N;
			ST_UNLINK_N: begin
				state_d = ((diff_q != '0) && rem_ok) ? ST_PUSH_REC : ST_DONE;
			end
			ST_PUSH_REC:  state_d = ST_PUSH_PREV;
			ST_PUSH_PREV: state_d = ST_DONE;
			ST_BUMP:      state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: handshake and memory access
	always_comb begin
		in_ready    = 1'b0;
		res_valid   = 1'b0;
		mem_rd_en   = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_mask = '0;
		mem_addr    = cur_q[AW-1:0];
		mem_wr_size = push_size_q;
		mem_wr_prev = NONE;
		mem_wr_next = head_q;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_START: begin
				if ((mode_q == MODE_ALLOC) && !too_big && head_ok) begin
					mem_rd_en = 1'b1;
					mem_addr  = head_q[AW-1:0];
				end
			end
			ST_WALK: begin
				if (!fit && walk_more) begin
					mem_rd_en = 1'b1;
					mem_addr  = mem_rd_next[AW-1:0];
				end
			end
			ST_UNLINK_P: begin
				mem_wr_en        = ptr_ok(prev_q);
				mem_wr_mask.next = 1'b1;
				mem_addr         = prev_q[AW-1:0];
				mem_wr_next      = next_q;
			end
			ST_UNLINK_N: begin
				mem_wr_en        = ptr_ok(next_q);
				mem_wr_mask.prev = 1'b1;
				mem_addr         = next_q[AW-1:0];
				mem_wr_prev      = prev_q;
			end
			ST_PUSH_REC: begin
				mem_wr_en   = 1'b1;
				mem_wr_mask = '{size: 1'b1, prev: 1'b1, next: 1'b1};
				mem_addr    = push_idx_q[AW-1:0];
			end
			ST_PUSH_PREV: begin
				mem_wr_en        = head_ok;
				mem_wr_mask.prev = 1'b1;
				mem_addr         = head_q[AW-1:0];
				mem_wr_prev      = push_idx_q;
			end
			ST_BUMP: begin
			end
			ST_DONE: res_valid = out_free;
			default: begin
			end
		endcase
	end

	// Result fields
	always_comb begin
		res.status       = status_q;
		res.position     = (mode_q == MODE_FREE) ? pos_q : grant_q;
		res.granted_size = (mode_q == MODE_FREE) ? size_q : rounded_q[SIZE_W-1:0];
		res.free_total   = free_bytes_q;
	end

	// Hold control state: state, list head, free total, bump pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= NONE;
			free_bytes_q <= '0;
			bump_q       <= HEAP_START_RST;
		end else begin
			state_q <= state_d;
			if (bump_load) begin
				bump_q <= bump_value;
			end else if ((state_q == ST_BUMP) && bump_ok) begin
				bump_q <= bump_sum[SIZE_W-1:0];
			end
			if (state_q == ST_UNLINK_P) begin
				if (!ptr_ok(prev_q)) begin
					head_q <= next_q;
				end
				free_bytes_q <= sat_sub(free_bytes_q, nsize_q);
			end else if (state_q == ST_PUSH_PREV) begin
				head_q       <= push_idx_q;
				free_bytes_q <= sat_add(free_bytes_q, push_size_q);
			end
		end
	end

	// Capture the request and the working values of the walk
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					mode_q    <= in_mode;
					size_q    <= in_size;
					pos_q     <= in_pos;
					rounded_q <= rounded_in;
				end
			end
			ST_START: begin
				cur_q       <= head_q;
				steps_q     <= '0;
				push_idx_q  <= free_idx[PW-1:0];
				push_size_q <= size_q;
				grant_q     <= '0;
				status_q    <= (mode_q == MODE_FREE) ? STATUS_OK : STATUS_NOSPACE;
			end
			ST_WALK: begin
				if (fit) begin
					prev_q   <= mem_rd_prev;
					next_q   <= mem_rd_next;
					nsize_q  <= mem_rd_size;
					diff_q   <= diff_w[SIZE_W-1:0];
					grant_q  <= cur_byte[POS_W-1:0];
					status_q <= STATUS_OK;
				end else begin
					cur_q   <= mem_rd_next;
					steps_q <= steps_nx;
				end
			end
			ST_UNLINK_N: begin
				push_idx_q  <= rem_idx[PW-1:0];
				push_size_q <= diff_q;
			end
			ST_BUMP: begin
				if (bump_ok) begin
					grant_q  <= bump_q[POS_W-1:0];
					status_q <= STATUS_OK;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/first_fit_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator: first-fit allocator over a granule arena
// Top level: configuration registers, request intake and result register.
// ----------------------------------------------------------------------------
// Usage
//   Requests enter on the s_ stream: s_tuser is the mode (allocate or free),
//   s_tdata carries the size and, for a free, the block position. Each request
//   gives exactly one result on the m_ stream: m_tuser is the no-space flag,
//   m_tdata the position, granted size and the free byte total after the step.
//   Requests are handled one at a time; s_tready is high while the sequencer
//   waits for work. The node records live in a single-port memory that the
//   sequencer accesses once per cycle. A free of a position inside the arena
//   pushes its block onto the list head; an oversized allocate ends at once;
//   any other allocate walks the free list from the head and either unlinks
//   the first fitting block, pushing any leftover back to the head, or takes
//   space from the bump pointer.
//   The walk examines one node per cycle through the memory read port.
//   Reset clears the list head, the free total, the bump pointer and the
//   registers to their defaults; the node memory needs no clearing pass.
//   A stalled m_tready holds the result; the sequencer then keeps its own
//   result and takes no new request until the register is taken.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle;
//   writing heap_start only reloads the bump pointer.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator
	import ffa_pkg::*;
#(
	parameter int ARENA_BYTES = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration write port
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [SIZE_W-1:0] cfg_data,
	// Request stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,  // size_bytes[16:0], block_position[32:17], zero pad
	input  logic              s_tuser,  // mode
	// Result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [55:0]       m_tdata,  // position[15:0], granted_size[32:16],
	                                    // free_total[49:33], zero pad
	output logic              m_tuser   // status
);

	cfg_t    cfg_q;
	logic    bump_load;
	logic    out_free;
	logic    res_valid;
	result_t res;
	result_t res_q;
	logic    m_tvalid_q;

	// Write configuration registers; heap_start only reloads the bump pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heap_limit    <= HEAP_LIMIT_RST;
			cfg_q.min_remainder <= MIN_REMAINDER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEAP_LIMIT:    cfg_q.heap_limit    <= cfg_data;
				REG_MIN_REMAINDER: cfg_q.min_remainder <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign bump_load = cfg_we && (cfg_index == REG_HEAP_START);

	ffa_ctrl #(
		.ARENA_BYTES (ARENA_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.bump_load  (bump_load),
		.bump_value (cfg_data & ~(SIZE_W'(7))),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_mode    (s_tuser),
		.in_size    (s_tdata[16:0]),
		.in_pos     (s_tdata[32:17]),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res        (res)
	);

	// Result register: load when empty or being drained
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {6'd0, res_q.free_total, res_q.granted_size, res_q.position};

endmodule
